// ----- src/ic3_pkg.sv -----
// Shared types and constants for the 3x3 convolution block.
`timescale 1ns / 1ps
package ic3_pkg;
  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned PixW   = 8;
  localparam int unsigned TapW   = 5;
  localparam int unsigned NumTaps = 9;
  localparam int unsigned KernW  = 45;
  localparam int unsigned DivW   = 8;
  localparam int unsigned OffW   = 9;
  localparam int unsigned WidW   = 10;
  localparam int unsigned HgtW   = 11;
  localparam int unsigned SumW   = 18;
  localparam int unsigned QuotW  = 14;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned PixMax = 255;

  typedef enum logic [AddrW-1:0] {
    RegKernel = 3'd0,
    RegDiv    = 3'd1,
    RegOff    = 3'd2,
    RegWidth  = 3'd3,
    RegHeight = 3'd4
  } reg_idx_e;

  // Job handed from front to back: window plus end-of-frame flag.
  typedef struct packed {
    logic [NumTaps-1:0][PixW-1:0] win;
    logic                         last;
  } job_t;

  typedef struct packed {
    logic [KernW-1:0] taps;
    logic [DivW-1:0]  divisor;
    logic [OffW-1:0]  offset;
  } arith_cfg_t;
endpackage

// ----- src/ic3_if.sv -----
// Valid/ready channel interfaces for pixel items.
`timescale 1ns / 1ps
interface ic3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ic3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- src/ic3_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ic3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- src/ic3_front.sv -----
// Front end: raster counters, line stores and 3x3 window; emits jobs.
`timescale 1ns / 1ps
module ic3_front #(
  parameter int unsigned MaxWidth  = ic3_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = ic3_pkg::MaxHeightDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [9:0]              width_i,
  input  logic [10:0]             height_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              pixel_i,
  output logic                    job_valid_o,
  output ic3_pkg::job_t           job_o,
  input  logic                    job_space_i
);
  import ic3_pkg::*;
  localparam int unsigned CW = $clog2(MaxWidth + 1);
  localparam int unsigned RW = $clog2(MaxHeight + 1);
  localparam int unsigned AW = $clog2(MaxWidth);

  // Two-phase: capture (read issued), then process with RAM data.
  logic         busy_q;
  logic [7:0]   pix_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [5:0][7:0] wc_q;
  logic [7:0]   top, mid;
  logic [CW-1:0] w_lim;
  logic [RW-1:0] h_lim;
  logic [AW-1:0] addr;
  logic         acc, we, emit;

  always_comb begin
    if (width_i < 10'd3) w_lim = CW'(3);
    else if (32'(width_i) > MaxWidth) w_lim = CW'(MaxWidth);
    else w_lim = CW'(width_i);
    if (height_i < 11'd3) h_lim = RW'(3);
    else if (32'(height_i) > MaxHeight) h_lim = RW'(MaxHeight);
    else h_lim = RW'(height_i);
  end

  assign in_ready_o = !busy_q;
  assign acc  = in_valid_i && in_ready_o;
  assign addr = col_q[AW-1:0];
  assign we   = busy_q && job_space_i && (32'(col_q) < MaxWidth);
  assign emit = (col_q >= CW'(2)) && (row_q >= RW'(2)) && (col_q < w_lim) && (row_q < h_lim);

  ic3_ram #(.Width(8), .Depth(MaxWidth)) u_upper (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(mid), .rdata_o(top));
  ic3_ram #(.Width(8), .Depth(MaxWidth)) u_middle (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(pix_q), .rdata_o(mid));

  assign job_valid_o = busy_q && job_space_i && emit;
  always_comb begin
    job_o.win  = {pix_q, wc_q[5], wc_q[2], mid, wc_q[4], wc_q[1], top, wc_q[3], wc_q[0]};
    job_o.last = (col_q == w_lim - CW'(1)) && (row_q == h_lim - RW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
      wc_q   <= '0;
      pix_q  <= '0;
    end else if (acc) begin
      busy_q <= 1'b1;
      pix_q  <= pixel_i;
    end else if (busy_q && job_space_i) begin
      busy_q <= 1'b0;
      wc_q   <= {pix_q, mid, top, wc_q[5], wc_q[4], wc_q[3]};
      if (col_q + CW'(1) >= w_lim) begin
        col_q <= '0;
        row_q <= (row_q + RW'(1) >= h_lim) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end
endmodule

// ----- src/ic3_fifo.sv -----
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module ic3_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ic3_pkg::job_t data_i,
  output logic          space_o,
  output logic          valid_o,
  output ic3_pkg::job_t data_o,
  input  logic          pop_i
);
  import ic3_pkg::*;
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  assign space_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];
  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ----- src/ic3_back.sv -----
// Back end: multiply-accumulate, serial divide, offset and clamp.
`timescale 1ns / 1ps
module ic3_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ic3_pkg::arith_cfg_t cfg_i,
  input  logic               job_valid_i,
  input  ic3_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         pixel_o,
  output logic               last_o
);
  import ic3_pkg::*;
  typedef enum logic [4:0] {
    SIdle = 5'b00001, SMac = 5'b00010, SDiv = 5'b00100,
    SFin  = 5'b01000, SOut = 5'b10000
  } state_e;
  state_e          st_q;
  job_t            job_q;
  logic [3:0]      k_q;
  logic signed [SumW-1:0] acc_q;
  logic [SumW-1:0] mag_q, rem_q;
  logic            neg_q;
  logic [4:0]      bit_q;
  logic [7:0]      pix_q;
  logic            last_q;
  logic signed [TapW-1:0] tap;
  logic signed [13:0] prod;
  logic [SumW:0]   trial;
  logic signed [SumW+1:0] res;
  logic signed [SumW:0]   quot;

  assign tap  = cfg_i.taps[k_q*TapW +: TapW];
  assign prod = $signed({6'b0, job_q.win[k_q]}) * 14'(tap);
  assign trial = {rem_q, mag_q[SumW-1]} - {11'b0, cfg_i.divisor};
  assign quot = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign res  = (SumW+2)'(quot) + (SumW+2)'($signed(cfg_i.offset));

  assign job_pop_o   = (st_q == SIdle) && job_valid_i;
  assign out_valid_o = st_q == SOut;
  assign pixel_o     = pix_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; k_q <= '0; bit_q <= '0;
      acc_q <= '0; mag_q <= '0; rem_q <= '0; neg_q <= 1'b0;
      pix_q <= '0; last_q <= 1'b0; job_q <= '0;
    end else begin
      case (st_q)
        SIdle: if (job_valid_i) begin
          job_q <= job_i; k_q <= '0; acc_q <= '0; st_q <= SMac;
        end
        SMac: begin
          acc_q <= acc_q + SumW'(prod);
          if (k_q == 4'(NumTaps - 1)) st_q <= SDiv;
          else k_q <= k_q + 4'd1;
          bit_q <= '0;
        end
        SDiv: begin
          if (bit_q == 5'd0) begin
            neg_q <= acc_q[SumW-1];
            mag_q <= acc_q[SumW-1] ? SumW'(-acc_q) : SumW'(acc_q);
            rem_q <= '0;
            bit_q <= 5'd1;
            if (cfg_i.divisor <= 8'd1) st_q <= SFin;
          end else begin
            if (!trial[SumW]) begin
              rem_q <= trial[SumW-1:0];
              mag_q <= {mag_q[SumW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[SumW-2:0], mag_q[SumW-1]};
              mag_q <= {mag_q[SumW-2:0], 1'b0};
            end
            if (bit_q == 5'(SumW)) st_q <= SFin;
            bit_q <= bit_q + 5'd1;
          end
        end
        SFin: begin
          if (res < 0) pix_q <= '0;
          else if (res > (SumW+2)'(PixMax)) pix_q <= 8'(PixMax);
          else pix_q <= res[7:0];
          last_q <= job_q.last;
          st_q <= SOut;
        end
        SOut: if (out_ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

// ----- src/image_convolution_3x3.sv -----
// Top level of the 3x3 image convolution block.
`timescale 1ns / 1ps
// Streams 8-bit grayscale pixels in raster order, keeps two line stores in
// RAM and a 3x3 window, and for each interior pixel gives the weighted sum
// of nine signed 5-bit taps divided by the divisor (toward zero), plus the
// offset, clamped to 0..255; frame_last marks the last interior result.
// Input takes a new pixel only once the previous one is done (line RAM read,
// then window update), and waits while the queue is full. Each result goes
// through the back end as idle, 9 MAC steps, sign/magnitude, finish and
// output, with 18 more serial divide steps when divisor > 1, plus any stall
// on the result channel, so interior throughput is set by the back-end
// sequencer; a two-entry queue decouples the two sides.
// Registers (APB, 64-bit data, byte address 8*i): 0 kernel taps,
// 1 divisor, 2 offset, 3 width, 4 height. No clearing pass after reset.
module image_convolution_3x3 #(
  parameter int unsigned MaxWidth  = ic3_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = ic3_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ic3_in_if.sink      in_if,
  ic3_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ic3_pkg::*;
  logic [KernW-1:0] taps_q;
  logic [DivW-1:0]  div_q;
  logic [OffW-1:0]  off_q;
  logic [WidW-1:0]  wid_q;
  logic [HgtW-1:0]  hgt_q;
  reg_idx_e         idx;
  logic             wr;
  arith_cfg_t       acfg;
  logic             jv, space, fv, pop;
  job_t             job, fjob;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= KernW'(1048576); div_q <= 8'd1; off_q <= '0;
      wid_q <= 10'd320; hgt_q <= 11'd240;
    end else if (wr) begin
      case (idx)
        RegKernel: taps_q <= pwdata[KernW-1:0];
        RegDiv:    div_q  <= pwdata[DivW-1:0];
        RegOff:    off_q  <= pwdata[OffW-1:0];
        RegWidth:  wid_q  <= pwdata[WidW-1:0];
        RegHeight: hgt_q  <= pwdata[HgtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegKernel: prdata = 64'(taps_q);
      RegDiv:    prdata = 64'(div_q);
      RegOff:    prdata = 64'(off_q);
      RegWidth:  prdata = 64'(wid_q);
      RegHeight: prdata = 64'(hgt_q);
      default:   prdata = '0;
    endcase
  end

  assign acfg = '{taps: taps_q, divisor: div_q, offset: off_q};

  ic3_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni, .width_i(wid_q), .height_i(hgt_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .pixel_i(in_if.pixel_in),
    .job_valid_o(jv), .job_o(job), .job_space_i(space));

  ic3_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(jv), .data_i(job), .space_o(space),
    .valid_o(fv), .data_o(fjob), .pop_i(pop));

  ic3_back u_back (
    .clk_i, .rst_ni, .cfg_i(acfg), .job_valid_i(fv), .job_i(fjob), .job_pop_o(pop),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .pixel_o(out_if.pixel_out), .last_o(out_if.frame_last));
endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the 3x3 convolution block: directed and random frames.
`timescale 1ns / 1ps
module testbench;
  import ic3_pkg::*;

  typedef struct {
    logic [7:0] pixel;
    logic       last;
  } conv_result_t;

  // Scoreboard: mirrors the block's registers, line stores and window, and
  // queues the filtered pixel each accepted interior input item should give.
  class conv_scoreboard;
    logic [KernW-1:0] taps;
    logic [DivW-1:0]  divisor;
    logic [OffW-1:0]  offset;
    logic [WidW-1:0]  width_reg;
    logic [HgtW-1:0]  height_reg;
    logic [7:0]       upper_line[MaxWidthDef];
    logic [7:0]       middle_line[MaxWidthDef];
    logic [7:0]       win_cols[6];
    int unsigned      col;
    int unsigned      row;
    conv_result_t     expected_q[$];
    int               errors;

    function new();
      taps       = 45'h100000;
      divisor    = 8'd1;
      offset     = '0;
      width_reg  = 10'd320;
      height_reg = 11'd240;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win_cols[i]) win_cols[i] = '0;
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp(width_reg, MaxWidthDef);
    endfunction

    function int unsigned eff_height();
      return clamp(height_reg, MaxHeightDef);
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] v);
      case (idx)
        RegKernel: taps       = v[KernW-1:0];
        RegDiv:    divisor    = v[DivW-1:0];
        RegOff:    offset     = v[OffW-1:0];
        RegWidth:  width_reg  = v[WidW-1:0];
        RegHeight: height_reg = v[HgtW-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] pix);
      int unsigned  w;
      int unsigned  h;
      logic [7:0]   top;
      logic [7:0]   mid;
      logic [7:0]   win[9];
      int           sum;
      conv_result_t res;
      w   = eff_width();
      h   = eff_height();
      top = '0;
      mid = '0;
      if (col < MaxWidthDef) begin
        top = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = pix;
      end
      // rows top/middle/bottom, columns c-2, c-1, c
      win[0] = win_cols[0]; win[1] = win_cols[3]; win[2] = top;
      win[3] = win_cols[1]; win[4] = win_cols[4]; win[5] = mid;
      win[6] = win_cols[2]; win[7] = win_cols[5]; win[8] = pix;
      if (col >= 2 && row >= 2 && col < w && row < h) begin
        sum = 0;
        for (int i = 0; i < NumTaps; i++)
          sum += int'(win[i]) * int'($signed(taps[TapW*i +: TapW]));
        if (divisor > 1) sum = sum / int'(divisor);
        sum += int'($signed(offset));
        if (sum < 0) sum = 0;
        if (sum > PixMax) sum = PixMax;
        res.pixel = sum[7:0];
        res.last  = (col == w - 1 && row == h - 1);
        expected_q.push_back(res);
      end
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = top;
      win_cols[4] = mid;
      win_cols[5] = pix;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_result(logic [7:0] pix, logic last);
      conv_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pixel_out=%0d frame_last=%0b", $time, pix, last);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (pix !== exp_res.pixel) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, exp_res.pixel, pix);
        errors++;
      end
      if (last !== exp_res.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ic3_in_if  in_if ();
  ic3_out_if out_if ();

  image_convolution_3x3 dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  conv_scoreboard sb = new();

  // no_idle: both sides run flat out while set
  bit no_idle;
  int sink_stall;
  int items_sent;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sink side: random back-pressure on the result channel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_stall   <= 0;
    end else if (sink_stall > 0) begin
      out_if.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
      sink_stall   <= pick_gap();
    end
  end

  // Result monitor: values read here are those before this edge's updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.pixel_out, out_if.frame_last);
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    // back end may still be busy with nothing queued
    repeat (64) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.pixel_in <= pix;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_pixel(pix);
    items_sent++;
  endtask

  // One phase: idle the block, program every register, send whole frames.
  // extremes: pixels only 0 or 255. hold_at: pause for drain after that item.
  // Input valid is low on entry and left low on return.
  task automatic run_frames(logic [44:0] taps, logic [7:0] div, logic [8:0] off,
                            logic [9:0] w, logic [10:0] h, int frames,
                            bit extremes, int hold_at);
    int n;
    wait_drained();
    write_reg(RegKernel, {19'h0, taps});
    write_reg(RegDiv, {56'h0, div});
    write_reg(RegOff, {55'h0, off});
    write_reg(RegWidth, {54'h0, w});
    write_reg(RegHeight, {53'h0, h});
    n = sb.eff_width() * sb.eff_height() * frames;
    for (int i = 0; i < n; i++) begin
      if (extremes) send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
      else send_pixel(8'($urandom_range(0, 255)));
      if (i == hold_at) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (sb.expected_q.size() != 0);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  function automatic logic [44:0] rand_taps();
    return 45'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] rand_div();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'd1;
    if (r == 3) return 8'd0;
    if (r == 4) return 8'd255;
    return 8'($urandom_range(2, 40));
  endfunction

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.pixel_in = '0;
    no_idle        = 1'b0;
    items_sent     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all taps +15, divisor zero (taken as 1) -> clamps high.
    run_frames({9{5'd15}}, 8'd0, 9'd0, 10'd3, 11'd3, 1, 1'b1, -1);
    // All taps -16, divisor 255, offset -255; width 0 and height 1 saturate to 3.
    run_frames({9{5'h10}}, 8'd255, 9'h101, 10'd0, 11'd1, 1, 1'b1, -1);
    // Identity kernel, offset +255, pure 255 and 0 pixels.
    run_frames(45'h100000, 8'd1, 9'd255, 10'd3, 11'd3, 1, 1'b1, -1);

    // Random: small frames, random arithmetic; a few phases with no idling.
    while (items_sent < 900) begin
      no_idle = ($urandom_range(0, 5) == 0);
      run_frames(rand_taps(), rand_div(), 9'($urandom_range(0, 511)),
                 10'($urandom_range(3, 10)), 11'($urandom_range(3, 8)),
                 $urandom_range(1, 3), 1'b0,
                 (items_sent < 200) ? 20 : -1);
    end
    no_idle = 1'b0;

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("image_convolution_3x3 test passed");
    end else begin
      $display("image_convolution_3x3 test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("image_convolution_3x3 test failed");
    $finish;
  end
endmodule
